[rtl/tga_rle_pkg.sv]
package tga_rle_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam int unsigned HDR_RUN_BIT = 7;

  typedef enum logic [1:0] {
    REG_RUN_LENGTH_CODED = 2'd0,
    REG_HAS_ALPHA        = 2'd1,
    REG_TOTAL_PIXELS     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic        run_length_coded;
    logic        has_alpha;
    logic [31:0] total_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       image_end;
  } pixel_t;

endpackage

[rtl/tga_rle_regs.sv]
module tga_rle_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tga_rle_pkg::AddrWidth-1:0]    paddr,
  input  logic [tga_rle_pkg::DataWidth-1:0]    pwdata,
  output logic [tga_rle_pkg::DataWidth-1:0]    prdata,
  output logic                                 pready,
  output tga_rle_pkg::cfg_t                    cfg
);

  logic        wr_en;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        tga_rle_pkg::REG_RUN_LENGTH_CODED: cfg.run_length_coded <= pwdata[0];
        tga_rle_pkg::REG_HAS_ALPHA:        cfg.has_alpha        <= pwdata[0];
        tga_rle_pkg::REG_TOTAL_PIXELS:     cfg.total_pixels     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tga_rle_pkg::REG_RUN_LENGTH_CODED: prdata = {31'd0, cfg.run_length_coded};
      tga_rle_pkg::REG_HAS_ALPHA:        prdata = {31'd0, cfg.has_alpha};
      tga_rle_pkg::REG_TOTAL_PIXELS:     prdata = cfg.total_pixels;
      default:                           prdata = '0;
    endcase
  end

endmodule

[rtl/tga_rle_core.sv]
module tga_rle_core (
  input  logic                  clk,
  input  logic                  rst,
  input  tga_rle_pkg::cfg_t     cfg,
  input  logic                  byte_valid,
  input  logic [7:0]            byte_data,
  input  logic                  advance,
  output logic                  res_valid,
  output tga_rle_pkg::pixel_t   res
);

  logic        expect_header;
  logic        packet_is_run;
  logic [7:0]  packet_left;
  logic [1:0]  byte_in_pixel;
  logic [23:0] held_colour;
  logic [31:0] pixels_done;

  logic        expect_header_next;
  logic        packet_is_run_next;
  logic [7:0]  packet_left_next;
  logic [1:0]  byte_in_pixel_next;
  logic [23:0] held_colour_next;
  logic [31:0] pixels_done_next;

  logic        fire;
  logic        is_header;
  logic        is_final;
  logic [32:0] diff;
  logic [31:0] remaining;
  logic [7:0]  repeat_raw;
  logic        at_end;

  assign fire      = byte_valid && advance && (cfg.total_pixels != '0);
  assign is_header = cfg.run_length_coded && expect_header && (byte_in_pixel == 2'd0);
  assign is_final  = (byte_in_pixel == 2'd3) || ((byte_in_pixel == 2'd2) && !cfg.has_alpha);

  assign diff       = {1'b0, cfg.total_pixels} - {1'b0, pixels_done};
  assign remaining  = (!diff[32] && (diff[31:0] != '0)) ? diff[31:0] : 32'd1;
  assign repeat_raw = (cfg.run_length_coded && packet_is_run && (packet_left != '0))
                      ? packet_left : 8'd1;
  assign at_end     = {24'd0, repeat_raw} >= remaining;

  always_comb begin
    res_valid              = fire && !is_header && is_final;
    res.red                = (byte_in_pixel == 2'd2) ? byte_data : held_colour[23:16];
    res.green              = held_colour[15:8];
    res.blue               = held_colour[7:0];
    res.alpha              = (cfg.has_alpha && (byte_in_pixel == 2'd3))
                             ? byte_data : tga_rle_pkg::ALPHA_OPAQUE;
    res.repeat_res         = at_end ? remaining[7:0] : repeat_raw;
    res.image_end          = at_end;
  end

  always_comb begin
    expect_header_next = expect_header;
    packet_is_run_next = packet_is_run;
    packet_left_next   = packet_left;
    byte_in_pixel_next = byte_in_pixel;
    held_colour_next   = held_colour;
    pixels_done_next   = pixels_done;
    if (fire) begin
      if (is_header) begin
        packet_is_run_next = byte_data[tga_rle_pkg::HDR_RUN_BIT];
        packet_left_next   = {1'b0, byte_data[6:0]} + 8'd1;
        expect_header_next = 1'b0;
      end else if (!is_final) begin
        case (byte_in_pixel)
          2'd0:    held_colour_next[7:0]   = byte_data;
          2'd1:    held_colour_next[15:8]  = byte_data;
          2'd2:    held_colour_next[23:16] = byte_data;
          default: ;
        endcase
        byte_in_pixel_next = byte_in_pixel + 2'd1;
      end else begin
        byte_in_pixel_next = 2'd0;
        if (byte_in_pixel == 2'd2) begin
          held_colour_next[23:16] = byte_data;
        end
        if (at_end) begin
          expect_header_next = 1'b1;
          packet_is_run_next = 1'b0;
          packet_left_next   = '0;
          held_colour_next   = '0;
          pixels_done_next   = '0;
        end else begin
          pixels_done_next = pixels_done + {24'd0, repeat_raw};
          if (cfg.run_length_coded) begin
            if (packet_is_run || (packet_left <= 8'd1)) begin
              packet_left_next   = '0;
              expect_header_next = 1'b1;
            end else begin
              packet_left_next = packet_left - 8'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      packet_is_run <= 1'b0;
      packet_left   <= '0;
      byte_in_pixel <= '0;
      pixels_done   <= '0;
    end else begin
      expect_header <= expect_header_next;
      packet_is_run <= packet_is_run_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixels_done   <= pixels_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_colour <= '0;
    end else begin
      held_colour <= held_colour_next;
    end
  end

endmodule

[rtl/tga_rle_pixel_decoder.sv]
// Decodes the pixel payload of a true-colour targa image, one byte per beat,
// into pixels of red, green, blue and alpha with a repeat count; the last
// pixel of the image carries image_end and the decoder then waits for the
// next image. A byte is taken every cycle unless out_ready stalls the output:
// it is held in an input register, decoded combinationally against the packet
// and pixel state, and a finished pixel waits in an output register. Throughput
// is one byte per cycle when unstalled, set by the single state update per byte.
// Registers are to be written through the APB port at byte addresses 0
// (run_length_coded), 4 (has_alpha) and 8 (total_pixels) only while the
// decoder is idle; the block itself does not enforce this.
module tga_rle_pixel_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tga_rle_pkg::AddrWidth-1:0]    paddr,
  input  logic [tga_rle_pkg::DataWidth-1:0]    pwdata,
  output logic [tga_rle_pkg::DataWidth-1:0]    prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           data_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           red,
  output logic [7:0]                           green,
  output logic [7:0]                           blue,
  output logic [7:0]                           alpha,
  output logic [7:0]                           repeat_res,
  output logic                                 image_end
);

  tga_rle_pkg::cfg_t   cfg;
  tga_rle_pkg::pixel_t res;
  tga_rle_pkg::pixel_t out_pix;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       advance;
  logic       res_valid;

  tga_rle_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_byte <= data_byte;
    end
  end

  tga_rle_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (in_q_valid),
    .byte_data  (in_q_byte),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_pix <= res;
    end
  end

  assign red        = out_pix.red;
  assign green      = out_pix.green;
  assign blue       = out_pix.blue;
  assign alpha      = out_pix.alpha;
  assign repeat_res = out_pix.repeat_res;
  assign image_end  = out_pix.image_end;

`ifndef SYNTHESIS
  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (repeat_res != 8'd0) && (repeat_res <= 8'd128))
    else $error("repeat count out of range");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !advance) |=> (in_q_valid && $stable(in_q_byte)))
    else $error("buffered byte lost while stalled");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_q_valid))
    else $error("result without a buffered byte");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int ITEM_TARGET = 650;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_AFTER = 40;
  localparam int HOLD_CYCLES = 150;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tga_rle_pkg::AddrWidth-1:0] paddr = '0;
  logic [tga_rle_pkg::DataWidth-1:0] pwdata = '0;
  logic [tga_rle_pkg::DataWidth-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red, green, blue, alpha, repeat_res;
  logic image_end;

  tga_rle_pixel_decoder uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .data_byte,
    .out_valid, .out_ready, .red, .green, .blue, .alpha, .repeat_res, .image_end
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tga_rle_pkg::cfg_t cfg_model;
  logic awaiting_header;
  logic in_run_packet;
  logic [7:0] packet_count;
  logic [1:0] byte_pos;
  logic [23:0] colour_acc;
  logic [31:0] image_pixels;

  logic [7:0] byte_queue[$];
  tga_rle_pkg::pixel_t pixel_fifo[$];

  int bytes_offered = 0;
  int bytes_taken = 0;
  int pixels_checked = 0;
  int images_closed = 0;
  int reg_writes = 0;
  int fault_count = 0;
  int idle_cycles = 0;

  logic byte_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic [3:0] rx_slot = '0;
  logic [15:0] stall_mask = '1;

  function automatic void clear_image_state();
    awaiting_header = 1'b1;
    in_run_packet = 1'b0;
    packet_count = '0;
    byte_pos = '0;
    colour_acc = '0;
    image_pixels = '0;
  endfunction

  // Returns 1 when the byte completes a pixel; px then holds the expected beat.
  function automatic bit decode_byte(input logic [7:0] b, output tga_rle_pkg::pixel_t px);
    logic [1:0] last_pos;
    logic [31:0] rep;
    logic [31:0] missing;
    logic closes;
    px = '0;
    if (cfg_model.total_pixels == 0) return 1'b0;
    if (cfg_model.run_length_coded && awaiting_header && byte_pos == 2'd0) begin
      in_run_packet = b[tga_rle_pkg::HDR_RUN_BIT];
      packet_count = {1'b0, b[6:0]} + 8'd1;
      awaiting_header = 1'b0;
      return 1'b0;
    end
    last_pos = cfg_model.has_alpha ? 2'd3 : 2'd2;
    if (byte_pos < last_pos) begin
      colour_acc[8*byte_pos +: 8] = b;
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
    end
    if (byte_pos == 2'd2) colour_acc[23:16] = b;
    px.alpha = (cfg_model.has_alpha && byte_pos == 2'd3) ? b : tga_rle_pkg::ALPHA_OPAQUE;
    byte_pos = '0;
    rep = 32'd1;
    if (cfg_model.run_length_coded && in_run_packet && packet_count != 0) begin
      rep = {24'd0, packet_count};
    end
    missing = (cfg_model.total_pixels > image_pixels) ?
              cfg_model.total_pixels - image_pixels : 32'd1;
    closes = (rep >= missing);
    if (closes) rep = missing;
    px.red = colour_acc[23:16];
    px.green = colour_acc[15:8];
    px.blue = colour_acc[7:0];
    px.repeat_res = rep[7:0];
    px.image_end = closes;
    if (closes) begin
      clear_image_state();
      return 1'b1;
    end
    image_pixels = image_pixels + rep;
    if (cfg_model.run_length_coded) begin
      if (in_run_packet || packet_count <= 8'd1) begin
        packet_count = '0;
        awaiting_header = 1'b1;
      end else begin
        packet_count = packet_count - 8'd1;
      end
    end
    return 1'b1;
  endfunction

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%s", what);
  endfunction

  task automatic offer_byte(input logic [7:0] b);
    byte_queue.push_back(b);
    if (cfg_model.total_pixels != 0) bytes_offered++;
  endtask

  task automatic offer_seq(input logic [95:0] seq, input int n);
    for (int i = n - 1; i >= 0; i--) offer_byte(seq[8*i +: 8]);
  endtask

  task automatic write_reg(input tga_rle_pkg::reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tga_rle_pkg::REG_RUN_LENGTH_CODED: cfg_model.run_length_coded = value[0];
      tga_rle_pkg::REG_HAS_ALPHA: cfg_model.has_alpha = value[0];
      tga_rle_pkg::REG_TOTAL_PIXELS: cfg_model.total_pixels = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_decoder();
    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
    while (pixel_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_bytes(input int budget);
    int sent;
    int count;
    int npix;
    int bpp;
    logic is_run;
    sent = 0;
    while (sent < budget) begin
      bpp = cfg_model.has_alpha ? 4 : 3;
      if (cfg_model.run_length_coded && $urandom_range(0, 9) != 0) begin
        is_run = 1'($urandom_range(0, 1));
        count = (is_run && $urandom_range(0, 2) == 0) ? $urandom_range(0, 127) :
                $urandom_range(0, 6);
        offer_byte({is_run, 7'(count)});
        npix = is_run ? 1 : count + 1;
        repeat (npix * bpp) offer_byte(8'($urandom_range(0, 255)));
        sent += 1 + npix * bpp;
      end else if ($urandom_range(0, 9) == 0) begin
        offer_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end else begin
        repeat (bpp) offer_byte(8'($urandom_range(0, 255)));
        sent += bpp;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_valid <= 1'b1;
        data_byte <= byte_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = $urandom_range(0, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && pixels_checked >= HOLD_AFTER && in_valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_slot == 4'd0) begin
        stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                     16'($urandom() | $urandom());
      end
      out_ready <= stall_mask[rx_slot];
      rx_slot = rx_slot + 4'd1;
    end
  end

  always @(posedge clk) begin
    tga_rle_pkg::pixel_t predicted;
    tga_rle_pkg::pixel_t oldest;
    tga_rle_pkg::pixel_t got;
    byte_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        byte_taken = 1'b1;
        bytes_taken++;
        if (decode_byte(data_byte, predicted)) pixel_fifo.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        got.red = red;
        got.green = green;
        got.blue = blue;
        got.alpha = alpha;
        got.repeat_res = repeat_res;
        got.image_end = image_end;
        if (pixel_fifo.size() == 0) begin
          note_fault($sformatf("Unexpected pixel beat %0d: %02h %02h %02h %02h x%0d end=%0b",
                               pixels_checked, got.red, got.green, got.blue, got.alpha,
                               got.repeat_res, got.image_end));
        end else begin
          oldest = pixel_fifo.pop_front();
          if (got !== oldest) begin
            note_fault($sformatf({"Pixel beat %0d: expected %02h %02h %02h %02h x%0d end=%0b,",
                                  " got %02h %02h %02h %02h x%0d end=%0b"},
                                 pixels_checked, oldest.red, oldest.green, oldest.blue,
                                 oldest.alpha, oldest.repeat_res, oldest.image_end,
                                 got.red, got.green, got.blue, got.alpha,
                                 got.repeat_res, got.image_end));
          end
        end
        pixels_checked++;
        if (got.image_end === 1'b1) images_closed++;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
    $display("[tga_rle_pixel_decoder] ERROR");
    $finish;
  end

  initial begin
    int budget;
    logic [31:0] span;
    cfg_model = '0;
    clear_image_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With no pixels in the image every byte is dropped.
    offer_seq(96'hFF_00, 2);
    drain_decoder();

    write_reg(tga_rle_pkg::REG_RUN_LENGTH_CODED, 32'd0);
    write_reg(tga_rle_pkg::REG_HAS_ALPHA, 32'd0);
    write_reg(tga_rle_pkg::REG_TOTAL_PIXELS, 32'd2);
    offer_seq(96'h000000_FFFFFF, 6);
    drain_decoder();

    // Leave the next image waiting for its alpha byte, then switch to
    // three-byte pixels.
    write_reg(tga_rle_pkg::REG_HAS_ALPHA, 32'd1);
    write_reg(tga_rle_pkg::REG_TOTAL_PIXELS, 32'd1);
    offer_seq(96'h01020408_102040, 7);
    drain_decoder();
    write_reg(tga_rle_pkg::REG_HAS_ALPHA, 32'd0);
    offer_byte(8'h80);
    drain_decoder();

    // A full run, then a literal packet that overruns the image; its leftover
    // bytes open the next image, whose run is cut to the new total.
    write_reg(tga_rle_pkg::REG_RUN_LENGTH_CODED, 32'd1);
    write_reg(tga_rle_pkg::REG_TOTAL_PIXELS, 32'd129);
    offer_seq(96'hFFAA55C3_023C5A96_99E77E, 11);
    drain_decoder();
    write_reg(tga_rle_pkg::REG_TOTAL_PIXELS, 32'd3);
    offer_byte(8'h81);
    drain_decoder();

    while (bytes_offered < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) begin
        write_reg(tga_rle_pkg::REG_RUN_LENGTH_CODED, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(tga_rle_pkg::REG_HAS_ALPHA, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0: span = 32'd0;
          1: span = 32'd1;
          2: span = 32'hFFFE0001;
          3: span = 32'hFFFFFFFF;
          4, 5, 6, 7, 8, 9, 10, 11: span = $urandom_range(2, 12);
          default: span = $urandom_range(13, 300);
        endcase
        write_reg(tga_rle_pkg::REG_TOTAL_PIXELS, span);
      end
      budget = $urandom_range(20, 50);
      queue_random_bytes(budget);
      drain_decoder();
    end

    $display("Run covered %0d payload beats and %0d pixel beats, %0d of which ended an image.",
             bytes_taken, pixels_checked, images_closed);
    $display("Settings changed by %0d register writes across raw and packet modes.",
             reg_writes);
    if (fault_count == 0 && pixel_fifo.size() == 0) begin
      $display("[tga_rle_pixel_decoder] OK");
    end else begin
      $display("Failures: %0d, pixels still expected: %0d", fault_count, pixel_fifo.size());
      $display("[tga_rle_pixel_decoder] ERROR");
    end
    $finish;
  end

endmodule
